>>> design/fpwc_pkg.sv
// Package: shared types and constants of the frequent pattern word compressor.
package fpwc_pkg;

    localparam int MAX_ZERO_RUN_DEF    = 8;
    localparam int MAX_BLOCK_WORDS_DEF = 16;
    localparam int RESULT_DEPTH        = 4;

    localparam int WORD_W   = 32;
    localparam int PREFIX_W = 3;
    localparam int BITS_W   = 6;
    localparam int SIZE_W   = 3;
    localparam int TOTAL_W  = 7;
    localparam int RUN_W    = 4;

    // pattern codes
    localparam logic [PREFIX_W-1:0] PFX_ZERO_RUN = 3'd0;
    localparam logic [PREFIX_W-1:0] PFX_NIBBLE   = 3'd1;
    localparam logic [PREFIX_W-1:0] PFX_BYTE     = 3'd2;
    localparam logic [PREFIX_W-1:0] PFX_HALF     = 3'd3;
    localparam logic [PREFIX_W-1:0] PFX_PAD_HALF = 3'd4;
    localparam logic [PREFIX_W-1:0] PFX_TWO_BYTE = 3'd5;
    localparam logic [PREFIX_W-1:0] PFX_REP_BYTE = 3'd6;
    localparam logic [PREFIX_W-1:0] PFX_RAW      = 3'd7;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 7'd127;

    // encoding of one word, without block accounting
    typedef struct packed {
        logic [PREFIX_W-1:0] prefix;
        logic [WORD_W-1:0]   payload;
        logic [BITS_W-1:0]   payload_bits;
        logic [SIZE_W-1:0]   size_bytes;
    } code_t;

    // one result entry as it leaves the block
    typedef struct packed {
        code_t              code;
        logic [TOTAL_W-1:0] block_bytes;
        logic               last_result;
    } result_t;

endpackage

>>> design/frequent_pattern_word_compressor_top.sv
// Top level: frequent pattern word compressor with zero-run gathering.
//
// Input channel s_*: one 32-bit word per transfer plus s_last_word, which
// closes the block. The MAX_BLOCK_WORDS-th word of a block closes it too.
// Result channel m_*: one encoded item per transfer (prefix, payload,
// payload width, bytes charged); m_block_bytes carries the block's total on
// the transfer with m_last_result set and is zero otherwise.
// Zero words produce no result of their own; they are gathered and sent as
// one zero-run item when a nonzero word arrives, the run reaches
// MAX_ZERO_RUN, or the block ends. A word may therefore cause zero, one or
// two results.
// A word in the input register is classified combinationally; its results
// enter the result queue. Throughput: one word per cycle while the queue
// has room, set by the single classify stage between the input register
// and a four-entry queue that absorbs the second result of a flushed run.
// Reset (aresetn low, synchronous) empties the input register and the
// queue and clears the run count, byte total and word count.
// When the receiver stalls, results collect in the queue; s_ready drops
// once fewer than two queue entries are free and the input register holds
// a word, so nothing is lost.
module frequent_pattern_word_compressor_top #(
    parameter int MAX_ZERO_RUN    = fpwc_pkg::MAX_ZERO_RUN_DEF,
    parameter int MAX_BLOCK_WORDS = fpwc_pkg::MAX_BLOCK_WORDS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [fpwc_pkg::WORD_W-1:0]     s_data_word,
    input  logic                            s_last_word,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [fpwc_pkg::PREFIX_W-1:0]   m_prefix,
    output logic [fpwc_pkg::WORD_W-1:0]     m_payload,
    output logic [fpwc_pkg::BITS_W-1:0]     m_payload_bits,
    output logic [fpwc_pkg::SIZE_W-1:0]     m_size_bytes,
    output logic [fpwc_pkg::TOTAL_W-1:0]    m_block_bytes,
    output logic                            m_last_result
);

    localparam int WCNT_W  = $clog2(MAX_BLOCK_WORDS + 1);
    localparam int RUN_W   = fpwc_pkg::RUN_W;
    localparam int TOTAL_W = fpwc_pkg::TOTAL_W;

    // saturating byte accounting
    function automatic logic [TOTAL_W-1:0] charge(input logic [TOTAL_W-1:0] total,
                                                   input logic [fpwc_pkg::SIZE_W-1:0] size);
        logic [TOTAL_W:0] sum;
        sum = {1'b0, total} + (TOTAL_W + 1)'(size);
        return sum[TOTAL_W] ? fpwc_pkg::TOTAL_MAX : sum[TOTAL_W-1:0];
    endfunction

    // input register
    logic                          in_valid_reg;
    logic [fpwc_pkg::WORD_W-1:0]   in_word_reg;
    logic                          in_last_reg;

    // block state
    logic [RUN_W-1:0]              run_reg, run_next;
    logic [TOTAL_W-1:0]            total_reg, total_next;
    logic [WCNT_W-1:0]             words_reg, words_next;

    logic                          room;
    logic                          advance;
    logic                          is_zero;
    logic                          block_end;
    logic [RUN_W-1:0]              run_inc;
    logic                          emit_run;
    logic [RUN_W-1:0]              run_len;
    logic [TOTAL_W-1:0]            total_run;
    logic [TOTAL_W-1:0]            total_word;
    logic                          run_is_last;
    fpwc_pkg::code_t               word_code;
    fpwc_pkg::result_t             run_entry;
    fpwc_pkg::result_t             word_entry;
    logic                          push0;
    logic                          push1;
    fpwc_pkg::result_t             push0_data;
    fpwc_pkg::result_t             out_data;

    assign advance = in_valid_reg && room;
    assign s_ready = !in_valid_reg || room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data_word;
            in_last_reg <= s_last_word;
        end
    end

    fpwc_classify u_classify (
        .data_word (in_word_reg),
        .code      (word_code)
    );

    // block end: explicit mark or word limit reached
    assign words_next = words_reg + WCNT_W'(1);
    assign block_end  = in_last_reg || (words_next >= WCNT_W'(MAX_BLOCK_WORDS));
    assign is_zero    = (in_word_reg == '0);
    assign run_inc    = run_reg + RUN_W'(1);

    // a zero word closes the run on limit or block end; a nonzero word
    // flushes whatever run is pending ahead of itself
    assign emit_run    = is_zero ? ((run_inc >= RUN_W'(MAX_ZERO_RUN)) || block_end)
                                 : (run_reg != '0);
    assign run_len     = is_zero ? run_inc : run_reg;
    assign run_is_last = is_zero && block_end;

    assign total_run  = charge(total_reg, 3'd1);
    assign total_word = charge(emit_run ? total_run : total_reg, word_code.size_bytes);

    always_comb begin
        run_entry.code.prefix       = fpwc_pkg::PFX_ZERO_RUN;
        run_entry.code.payload      = {29'd0, 3'(run_len - RUN_W'(1))};
        run_entry.code.payload_bits = 6'd3;
        run_entry.code.size_bytes   = 3'd1;
        run_entry.block_bytes       = run_is_last ? total_run : '0;
        run_entry.last_result       = run_is_last;

        word_entry.code        = word_code;
        word_entry.block_bytes = block_end ? total_word : '0;
        word_entry.last_result = block_end;
    end

    assign push0      = advance && (emit_run || !is_zero);
    assign push1      = advance && emit_run && !is_zero;
    assign push0_data = emit_run ? run_entry : word_entry;

    always_comb begin
        run_next   = run_reg;
        total_next = total_reg;
        if (block_end) begin
            run_next   = '0;
            total_next = '0;
        end else if (is_zero) begin
            run_next   = emit_run ? '0 : run_inc;
            total_next = emit_run ? total_run : total_reg;
        end else begin
            run_next   = '0;
            total_next = total_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= '0;
            total_reg <= '0;
            words_reg <= '0;
        end else if (advance) begin
            run_reg   <= run_next;
            total_reg <= total_next;
            words_reg <= block_end ? '0 : words_next;
        end
    end

    fpwc_result_fifo u_result_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push0      (push0),
        .push0_data (push0_data),
        .push1      (push1),
        .push1_data (word_entry),
        .room       (room),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_data   (out_data)
    );

    assign m_prefix       = out_data.code.prefix;
    assign m_payload      = out_data.code.payload;
    assign m_payload_bits = out_data.code.payload_bits;
    assign m_size_bytes   = out_data.code.size_bytes;
    assign m_block_bytes  = out_data.block_bytes;
    assign m_last_result  = out_data.last_result;

    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg < RUN_W'(MAX_ZERO_RUN))
        else $error("pending zero run reached its limit without a flush");

    a_words_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        words_reg < WCNT_W'(MAX_BLOCK_WORDS))
        else $error("block word count passed the block length");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        push1 |-> (push0 && push0_data.code.prefix == fpwc_pkg::PFX_ZERO_RUN
                   && !push0_data.last_result))
        else $error("second result pushed without a leading zero run");

    a_block_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && block_end) |=> (run_reg == '0 && total_reg == '0 && words_reg == '0))
        else $error("block state not cleared after block end");

endmodule

>>> design/fpwc_classify.sv
// Pattern classifier: maps one nonzero word to its prefix, payload and size.
module fpwc_classify (
    input  logic [fpwc_pkg::WORD_W-1:0] data_word,
    output fpwc_pkg::code_t             code
);

    logic [15:0] hi;
    logic [15:0] lo;
    logic        fits4;
    logic        fits8;
    logic        fits16;
    logic        hi_byte;
    logic        lo_byte;
    logic        rep;

    assign hi = data_word[31:16];
    assign lo = data_word[15:0];

    // sign-extension tests: all bits above the sign bit copy it
    assign fits4   = (data_word[31:3] == '0) || (data_word[31:3] == '1);
    assign fits8   = (data_word[31:7] == '0) || (data_word[31:7] == '1);
    assign fits16  = (data_word[31:15] == '0) || (data_word[31:15] == '1);
    assign hi_byte = (hi[15:7] == '0) || (hi[15:7] == '1);
    assign lo_byte = (lo[15:7] == '0) || (lo[15:7] == '1);
    assign rep     = (data_word[7:0] == data_word[15:8]) &&
                     (data_word[7:0] == data_word[23:16]) &&
                     (data_word[7:0] == data_word[31:24]);

    always_comb begin
        if (fits4) begin
            code = '{fpwc_pkg::PFX_NIBBLE, {28'd0, data_word[3:0]}, 6'd4, 3'd1};
        end else if (fits8) begin
            code = '{fpwc_pkg::PFX_BYTE, {24'd0, data_word[7:0]}, 6'd8, 3'd1};
        end else if (fits16) begin
            code = '{fpwc_pkg::PFX_HALF, {16'd0, lo}, 6'd16, 3'd2};
        end else if (lo == 16'd0) begin
            code = '{fpwc_pkg::PFX_PAD_HALF, {16'd0, hi}, 6'd16, 3'd2};
        end else if (hi_byte && lo_byte) begin
            code = '{fpwc_pkg::PFX_TWO_BYTE, {16'd0, hi[7:0], lo[7:0]}, 6'd16, 3'd2};
        end else if (rep) begin
            code = '{fpwc_pkg::PFX_REP_BYTE, {24'd0, data_word[7:0]}, 6'd8, 3'd1};
        end else begin
            code = '{fpwc_pkg::PFX_RAW, data_word, 6'd32, 3'd4};
        end
    end

endmodule

>>> design/fpwc_result_fifo.sv
// Result queue: takes up to two entries per cycle, delivers one per cycle while out_ready is high.
module fpwc_result_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push0,
    input  fpwc_pkg::result_t   push0_data,
    input  logic                push1,
    input  fpwc_pkg::result_t   push1_data,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output fpwc_pkg::result_t   out_data
);

    localparam int DEPTH = fpwc_pkg::RESULT_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    fpwc_pkg::result_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;
    logic [PTR_W-1:0]   wr_ptr_inc;

    assign room       = (count_reg <= CNT_W'(DEPTH - 2));
    assign out_valid  = (count_reg != '0);
    assign out_data   = mem_reg[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    assign wr_ptr_inc = wr_ptr_reg + PTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push0) + PTR_W'(push1);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push0) begin
            mem_reg[wr_ptr_reg] <= push0_data;
        end
        if (push1) begin
            mem_reg[wr_ptr_inc] <= push1_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue count beyond depth");

endmodule
